FILE: hw/rtl/bas_pkg.sv
// ---------------------------------------------------------------------------
// bas_pkg: shared codes and helpers for the byte argument stack
// Operation codes, stream payload widths and the pop sign-extension helper.
// ---------------------------------------------------------------------------
package bas_pkg;

   typedef logic [3:0] mode_type;

   localparam mode_type MODE_POP1   = 4'd0;
   localparam mode_type MODE_POP2   = 4'd1;
   localparam mode_type MODE_POP4   = 4'd2;
   localparam mode_type MODE_POP8   = 4'd3;
   localparam mode_type MODE_PUSH   = 4'd4;
   localparam mode_type MODE_ROTATE = 4'd5;
   localparam mode_type MODE_START  = 4'd6;
   localparam mode_type MODE_REWIND = 4'd7;
   localparam mode_type MODE_STOP   = 4'd8;
   localparam mode_type MODE_LOAD   = 4'd9;

   localparam int REQ_DATA_W = 40;   // 37 payload bits, padded to bytes
   localparam int RSP_DATA_W = 72;

   // Sign-extend a popped value of 1, 2, 4 or 8 bytes (size code 0..3).
   function automatic logic [63:0] pop_extend(input logic [63:0] v,
                                              input logic [1:0]  size,
                                              input logic        sext);
      logic [63:0] r;
      r = v;
      unique case (size)
         2'd0: r = {{56{sext & v[7]}},  v[7:0]};
         2'd1: r = {{48{sext & v[15]}}, v[15:0]};
         2'd2: r = {{32{sext & v[31]}}, v[31:0]};
         2'd3: r = v;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/byte_argument_stack.sv
// ---------------------------------------------------------------------------
// byte_argument_stack: byte-addressed argument stack with a read position
// Pops, pushes, rotates and loads on a byte store, one item at a time.
// ---------------------------------------------------------------------------
// One item is worked at a time; a new request is taken once the previous
// result sits in the output register, so a stalled consumer does not block
// the next transfer in. All byte traffic goes through one byte-wide store
// with one read and one write per cycle, and that port sets the cost: each
// byte of a pop, push, rotate or load, and each byte moved by the push-down
// shift (position below 2), passes the port on its own. Reads past the end
// give zero bytes, hold the position at STACK_BYTES and flag overrun; a
// rotate that would run past the end changes nothing and flags overrun.
// Store entries read as zero after reset (valid bit per byte), no clearing
// pass.
module byte_argument_stack
   import bas_pkg::*;
#(
   parameter int STACK_BYTES = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: operand_value[31:0], word_index[35:32], sign_extend[36], zero[39:37]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: mode[3:0]
   input  logic [3:0]            req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: pop_value[63:0], overrun[64], active[65], read_position[71:66]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(STACK_BYTES);
   localparam int PW = $clog2(STACK_BYTES + 1);   // position 0..STACK_BYTES
   localparam int SW = PW + 1;                    // position plus small offset

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_READ    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_SHIFT   = 3'd3;
   localparam logic [2:0] ST_SHDRAIN = 3'd4;
   localparam logic [2:0] ST_WRITE   = 3'd5;
   localparam logic [2:0] ST_FINISH  = 3'd6;

   // control
   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          active_ff, active_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          rv_ff, rv_in;        // read landing this cycle
   logic          mv_ff, mv_in;        // shift write pending
   logic          rsp_valid_ff, rsp_valid_in;
   // payload
   mode_type      mode_ff, mode_in;
   logic [31:0]   opnd_ff, opnd_in;
   logic [3:0]    idx_ff, idx_in;
   logic          sext_ff, sext_in;
   logic          ovr_ff, ovr_in;
   logic [63:0]   val_ff, val_in;
   logic [2:0]    rl_ff, rl_in;        // byte lane of the landing read
   logic [AW-1:0] sh_ff, sh_in;        // shift read address, descending
   logic [AW-1:0] mva_ff, mva_in;      // shift write address
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   // store port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   logic          req_fire;
   logic          is_pop, is_rot, is_load;
   logic [2:0]    rd_last, wr_last;
   logic [SW-1:0] rd_sum, wr_sum, pos_end;
   logic [63:0]   rot_word;
   mode_type      req_mode;

   bas_store #(.DEPTH(STACK_BYTES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_mode   = req_tuser;

   assign is_pop  = (mode_ff < MODE_PUSH);
   assign is_rot  = (mode_ff == MODE_ROTATE);
   assign is_load = (mode_ff == MODE_LOAD);

   // last byte count of the read and write sweeps
   always_comb begin
      rd_last = 3'd7;
      if (is_pop) begin
         unique case (mode_ff[1:0])
            2'd0: rd_last = 3'd0;
            2'd1: rd_last = 3'd1;
            2'd2: rd_last = 3'd3;
            2'd3: rd_last = 3'd7;
         endcase
      end
      priority if (is_rot) begin
         wr_last = 3'd7;
      end else if (is_load) begin
         wr_last = 3'd3;
      end else begin
         wr_last = 3'd1;            // push: low then high byte
      end
   end

   assign rd_sum   = SW'(pos_ff) + SW'(cnt_ff);
   assign wr_sum   = is_load ? SW'({idx_ff, cnt_ff[1:0]}) : rd_sum;
   assign pos_end  = SW'(pos_ff) + SW'(rd_last) + SW'(1);
   // W1..W4 become W4, W1, W2, W3
   assign rot_word = {val_ff[47:0], val_ff[63:48]};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      rv_in        = 1'b0;
      mv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mode_in      = mode_ff;
      opnd_in      = opnd_ff;
      idx_in       = idx_ff;
      sext_in      = sext_ff;
      ovr_in       = ovr_ff;
      val_in       = val_ff;
      rl_in        = cnt_ff;
      sh_in        = sh_ff;
      mva_in       = sh_ff + AW'(2);
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = AW'(wr_sum);
      wr_data      = is_rot ? 8'(rot_word >> {cnt_ff, 3'b000})
                            : 8'(opnd_ff >> {cnt_ff[1:0], 3'b000});

      // merge the byte that lands from the store
      for (int i = 0; i < 8; i++) begin
         if (rv_ff && (rl_ff == 3'(i))) begin
            val_in[8*i +: 8] = rd_data;
         end
      end

      // pending push-down move has the write port
      if (mv_ff) begin
         wr_en   = 1'b1;
         wr_addr = mva_ff;
         wr_data = rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in = req_mode;
               opnd_in = req_tdata[31:0];
               idx_in  = req_tdata[35:32];
               sext_in = req_tdata[36];
               ovr_in  = 1'b0;
               val_in  = '0;
               cnt_in  = '0;
               state_in = ST_FINISH;
               unique case (req_mode)
                  MODE_POP1, MODE_POP2, MODE_POP4, MODE_POP8: begin
                     state_in = ST_READ;
                  end
                  MODE_PUSH: begin
                     if (pos_ff >= PW'(2)) begin
                        pos_in   = pos_ff - PW'(2);
                        state_in = ST_WRITE;
                     end else begin
                        sh_in    = AW'(STACK_BYTES - 3);
                        state_in = ST_SHIFT;
                     end
                  end
                  MODE_ROTATE: begin
                     if (SW'(pos_ff) + SW'(8) > SW'(STACK_BYTES)) begin
                        ovr_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  MODE_START: begin
                     pos_in    = '0;
                     active_in = 1'b1;
                  end
                  MODE_REWIND: pos_in    = '0;
                  MODE_STOP:   active_in = 1'b0;
                  MODE_LOAD:   state_in  = ST_WRITE;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (rd_sum < SW'(STACK_BYTES)) begin
               rd_en   = 1'b1;
               rd_addr = AW'(rd_sum);
               rv_in   = 1'b1;
            end else begin
               ovr_in = 1'b1;       // past the end: zero byte
            end
            if (cnt_ff == rd_last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (is_rot) begin
               cnt_in   = '0;
               state_in = ST_WRITE;
            end else begin
               pos_in   = (pos_end > SW'(STACK_BYTES)) ? PW'(STACK_BYTES)
                                                       : PW'(pos_end);
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            // move store[a] to store[a+2], top down, write in the cycle after the read
            rd_en   = 1'b1;
            rd_addr = sh_ff;
            mv_in   = 1'b1;
            if (sh_ff == AW'(pos_ff)) begin
               state_in = ST_SHDRAIN;
            end else begin
               sh_in = sh_ff - AW'(1);
            end
         end
         ST_SHDRAIN: begin
            cnt_in   = '0;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en = (wr_sum < SW'(STACK_BYTES));
            if (cnt_ff == wr_last) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in = {6'(pos_ff), active_ff, ovr_ff,
                         is_pop ? pop_extend(val_ff, mode_ff[1:0], sext_ff)
                                : 64'd0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      opnd_ff <= opnd_in;
      idx_ff  <= idx_in;
      sext_ff <= sext_in;
      ovr_ff  <= ovr_in;
      val_ff  <= val_in;
      rl_ff   <= rl_in;
      sh_ff   <= sh_in;
      mva_ff  <= mva_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

FILE: hw/rtl/bas_store.sv
// ---------------------------------------------------------------------------
// bas_store: byte store of the argument stack
// One write and one registered read port; per-entry valid bits make an
// unwritten entry read as zero right after reset.
// ---------------------------------------------------------------------------
module bas_store #(
   parameter int DEPTH = 48,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [7:0]       q_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? q_ff : 8'h00;

endmodule

FILE: hw/rtl/bas_checker.sv
// ---------------------------------------------------------------------------
// bas_checker: port-level checks for the byte argument stack
// Watches both stream channels; bound to every instance of the top level.
// ---------------------------------------------------------------------------
module bas_checker
   import bas_pkg::*;
#(
   parameter int STACK_BYTES = 48
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0] open_ff;   // items taken but not yet delivered
   logic       in_fire, out_fire;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 2'(in_fire) - 2'(out_fire);
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no result without an item behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 2'd0)
      else $error("response without an accepted request");

   // one item in work plus one in the output register at most
   a_depth: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two items outstanding");

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // position never passes the end of the store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (STACK_BYTES >= 64) || (rsp_tdata[71:66] <= 6'(STACK_BYTES)))
      else $error("read position beyond the store");

endmodule

bind byte_argument_stack bas_checker #(.STACK_BYTES(STACK_BYTES)) u_bas_checker (.*);

FILE: test/stack_result_checker.sv
// ---------------------------------------------------------------------------
// stack_result_checker: response scoreboard for the byte argument stack
// Watches both stream channels, keeps a shadow copy of the byte store,
// read position and active flag, and compares every response transfer
// field by field against the oldest predicted outcome.
// ---------------------------------------------------------------------------
module stack_result_checker
   import bas_pkg::*;
#(
   parameter int STACK_BYTES = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [3:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    error_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [63:0] pop_value;
      logic        overrun;
      logic        active;
      logic [5:0]  read_position;
   } stack_outcome_type;

   logic [7:0]        shadow_bytes [STACK_BYTES];
   int                shadow_pos;
   logic              shadow_active;
   stack_outcome_type expected_outcomes [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Shadow model of one operation; updates the shadow state.
   function automatic stack_outcome_type apply_operation(input mode_type    mode,
                                                         input logic [31:0] operand,
                                                         input logic [3:0]  slot,
                                                         input logic        sext);
      stack_outcome_type res;
      int                count;
      int                i;
      int                addr;
      logic [7:0]        b;
      logic [7:0]        t0;
      logic [7:0]        t1;
      res   = '0;
      count = 0;
      case (mode)
         MODE_POP1: count = 1;
         MODE_POP2: count = 2;
         MODE_POP4: count = 4;
         MODE_POP8: count = 8;
         MODE_PUSH: begin
            if (shadow_pos >= 2) begin
               shadow_pos = shadow_pos - 2;
            end else begin
               for (i = STACK_BYTES - 1; i >= shadow_pos + 2; i--)
                  shadow_bytes[i] = shadow_bytes[i-2];
            end
            shadow_bytes[shadow_pos]     = operand[7:0];
            shadow_bytes[shadow_pos + 1] = operand[15:8];
         end
         MODE_ROTATE: begin
            if (shadow_pos + 8 > STACK_BYTES) begin
               res.overrun = 1'b1;
            end else begin
               t0 = shadow_bytes[shadow_pos + 6];
               t1 = shadow_bytes[shadow_pos + 7];
               for (i = 5; i >= 0; i--)
                  shadow_bytes[shadow_pos + i + 2] = shadow_bytes[shadow_pos + i];
               shadow_bytes[shadow_pos]     = t0;
               shadow_bytes[shadow_pos + 1] = t1;
            end
         end
         MODE_START: begin
            shadow_pos    = 0;
            shadow_active = 1'b1;
         end
         MODE_REWIND: shadow_pos = 0;
         MODE_STOP:   shadow_active = 1'b0;
         MODE_LOAD: begin
            for (i = 0; i < 4; i++) begin
               addr = int'(slot) * 4 + i;
               if (addr < STACK_BYTES)
                  shadow_bytes[addr] = operand[8*i +: 8];
            end
         end
         default: ;
      endcase

      // little-endian pop; bytes past the end read as zero
      for (i = 0; i < count; i++) begin
         if (shadow_pos < STACK_BYTES) begin
            b          = shadow_bytes[shadow_pos];
            shadow_pos = shadow_pos + 1;
         end else begin
            b           = 8'h00;
            shadow_pos  = STACK_BYTES;
            res.overrun = 1'b1;
         end
         res.pop_value = res.pop_value | (64'(b) << (8 * i));
      end
      if (sext && count > 0 && count < 8 && res.pop_value[8*count-1])
         res.pop_value = res.pop_value | ~((64'd1 << (8 * count)) - 64'd1);

      res.active        = shadow_active;
      res.read_position = shadow_pos[5:0];
      return res;
   endfunction

   always @(posedge clock) begin
      stack_outcome_type seen;
      stack_outcome_type want;
      if (reset) begin
         foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
         shadow_pos    = 0;
         shadow_active = 1'b0;
         expected_outcomes.delete();
      end else begin
         // responses first: a response never belongs to a same-cycle request
         if (rsp_tvalid && rsp_tready) begin
            seen.pop_value     = rsp_tdata[63:0];
            seen.overrun       = rsp_tdata[64];
            seen.active        = rsp_tdata[65];
            seen.read_position = rsp_tdata[71:66];
            if (expected_outcomes.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("unexpected response: value=%h ovr=%0b act=%0b pos=%0d",
                           seen.pop_value, seen.overrun, seen.active,
                           seen.read_position);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (seen.pop_value !== want.pop_value || seen.overrun !== want.overrun ||
                   seen.active !== want.active ||
                   seen.read_position !== want.read_position) begin
                  if (error_count < REPORT_LIMIT) begin
                     $write("mismatch: expected value=%h ovr=%0b act=%0b pos=%0d,",
                            want.pop_value, want.overrun, want.active,
                            want.read_position);
                     $display(" got value=%h ovr=%0b act=%0b pos=%0d",
                              seen.pop_value, seen.overrun, seen.active,
                              seen.read_position);
                  end
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(apply_operation(mode_type'(req_tuser),
                                                        req_tdata[31:0],
                                                        req_tdata[35:32],
                                                        req_tdata[36]));
      end
      pending_count <= expected_outcomes.size();
   end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the byte argument stack
// Directed corner items, then random operation mixes under four flow
// control phases plus a long response hold-off; a scoreboard alongside
// the block predicts and checks every response transfer.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bas_pkg::*;

   localparam int STACK_BYTES    = 48;
   localparam int PHASE_ITEMS    = 300;   // random items per flow phase
   localparam int HOLD_ITEMS     = 30;    // offered while the receiver holds off
   localparam int HOLD_CYCLES    = 400;   // length of the long response hold-off
   localparam int DRAIN_CYCLES   = 64;    // longer than the longest op, the push-down shift
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: operand_value[31:0], word_index[35:32], sign_extend[36], zero[39:37]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: mode[3:0]
   logic [3:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: pop_value[63:0], overrun[64], active[65], read_position[71:66]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int   error_count;
   int   pending_count;

   // flow control knobs, percent of cycles
   int   tx_idle_pct  = 0;
   int   rx_stall_pct = 0;
   logic hold_wanted  = 1'b0;
   int   hold_count   = 0;
   int   quiet_cycles = 0;

   always #4 clock = ~clock;

   byte_argument_stack #(.STACK_BYTES(STACK_BYTES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stack_result_checker #(.STACK_BYTES(STACK_BYTES)) scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Receiver: one long hold-off when asked (counted here), random stalls otherwise.
   always @(posedge clock) begin
      if (hold_wanted && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one request and hold it until the transfer; random idle gaps first.
   task automatic send_op(input mode_type    mode,
                          input logic [31:0] operand,
                          input logic [3:0]  slot,
                          input logic        sext);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, sext, slot, operand};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted response has come back.
   // The first edge lets the scoreboard count the last request transfer.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Operation mix: heavy on pops and pushes so the position wanders
   // over the whole store, with rewinds to pull it back from the end.
   function automatic mode_type pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 12)      return MODE_POP1;
      else if (r < 22) return MODE_POP2;
      else if (r < 32) return MODE_POP4;
      else if (r < 36) return MODE_POP8;
      else if (r < 66) return MODE_PUSH;
      else if (r < 76) return MODE_ROTATE;
      else if (r < 88) return MODE_LOAD;
      else if (r < 91) return MODE_START;
      else if (r < 95) return MODE_REWIND;
      else if (r < 97) return MODE_STOP;
      else             return mode_type'(10 + $urandom_range(5));  // unused codes
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0080;
         3:       return 32'h7FFF_7F7F;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(input int count);
      logic [3:0] slot;
      repeat (count) begin
         // mostly in-range load slots, sometimes the fully dropped ones
         slot = ($urandom_range(7) == 0) ? 4'(12 + $urandom_range(3))
                                         : 4'($urandom_range(11));
         send_op(pick_mode(), pick_operand(), slot, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);

      // ---- directed corners, no flow-control gaps ----
      send_op(MODE_POP1,   32'h0,          4'd0,  1'b1);  // pop before any start
      send_op(MODE_LOAD,   32'h8000_00FF,  4'd0,  1'b0);
      send_op(MODE_LOAD,   32'hFFFF_FFFF,  4'd1,  1'b0);
      send_op(MODE_LOAD,   32'h8081_8283,  4'd11, 1'b0);  // top slot
      send_op(MODE_LOAD,   32'h1234_5678,  4'd12, 1'b0);  // slot beyond the store
      send_op(MODE_START,  32'h0,          4'd0,  1'b0);
      send_op(MODE_POP1,   32'h0,          4'd0,  1'b1);  // 0xFF sign-extended
      send_op(MODE_POP1,   32'h0,          4'd0,  1'b0);
      send_op(MODE_POP2,   32'h0,          4'd0,  1'b1);  // 0x8000 sign-extended
      send_op(MODE_POP4,   32'h0,          4'd0,  1'b1);
      send_op(MODE_POP8,   32'h0,          4'd0,  1'b1);
      send_op(MODE_REWIND, 32'h0,          4'd0,  1'b0);
      send_op(MODE_ROTATE, 32'h0,          4'd0,  1'b0);
      send_op(MODE_PUSH,   32'h0000_FFFF,  4'd0,  1'b0);  // push-down shift at 0
      send_op(MODE_PUSH,   32'hABCD_8001,  4'd0,  1'b0);  // upper half ignored
      repeat (6) send_op(MODE_POP8, 32'h0, 4'd0, 1'b0);   // walk to the end
      send_op(MODE_POP4,   32'h0,          4'd0,  1'b1);  // pop past end
      send_op(MODE_ROTATE, 32'h0,          4'd0,  1'b0);  // rotate refused
      send_op(MODE_PUSH,   32'h0000_00FF,  4'd0,  1'b0);  // from the saturated end
      send_op(MODE_STOP,   32'h0,          4'd0,  1'b0);
      send_op(MODE_POP2,   32'h0,          4'd0,  1'b0);  // pop while inactive
      send_op(mode_type'(15), 32'hFFFF_FFFF, 4'd15, 1'b1); // unused code
      drain_responses();

      // ---- random phases ----
      run_random(PHASE_ITEMS);
      drain_responses();

      tx_idle_pct = 68;
      run_random(PHASE_ITEMS);
      drain_responses();

      tx_idle_pct  = 0;
      rx_stall_pct = 68;
      run_random(PHASE_ITEMS);
      drain_responses();

      tx_idle_pct  = 36;
      rx_stall_pct = 36;
      run_random(PHASE_ITEMS);
      drain_responses();

      // long receiver hold-off while requests keep coming: input backs up
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_wanted  <= 1'b1;
      run_random(HOLD_ITEMS);
      drain_responses();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: byte_argument_stack.f
hw/rtl/bas_pkg.sv
hw/rtl/bas_store.sv
hw/rtl/byte_argument_stack.sv
hw/rtl/bas_checker.sv
test/stack_result_checker.sv
test/tb_top.sv
